### sv/rrp_pkg.sv
// shared types and constants for the resp request parser
package rrp_pkg;

	// parser states
	typedef enum logic [2:0] {
		PS_START  = 3'd0,
		PS_INLINE = 3'd1,
		PS_LEN    = 3'd2,
		PS_LF     = 3'd3,
		PS_BUF    = 3'd4
	} ps_t;

	// kind of the item being parsed
	typedef enum logic [1:0] {
		IT_UNKNOWN = 2'd0,
		IT_ARRAY   = 2'd1,
		IT_BULK    = 2'd2,
		IT_INLINE  = 2'd3
	} it_t;

	// reported item kinds
	localparam logic [1:0] KIND_ARRAY  = 2'd0;
	localparam logic [1:0] KIND_BULK   = 2'd1;
	localparam logic [1:0] KIND_INLINE = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_ITEMS    = 2'd2;

	// character codes
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	localparam logic [15:0] BUF_SIZE_RESET = 16'd1024;

	// one result word
	typedef struct packed {
		logic        has_byte;
		logic [7:0]  data_byte;
		logic        item_end;
		logic [1:0]  item_kind;
		logic [2:0]  item_index;
		logic [31:0] item_length;
		logic        message_end;
		logic [1:0]  error;
	} rrp_result_t;

endpackage

### sv/rrp_core.sv
// parser state registers and the per-byte step logic
module rrp_core #(
	parameter int MAX_ITEMS   = 8,
	parameter int LENGTH_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           in_byte,
	input  logic [15:0]          buf_size,
	output rrp_pkg::rrp_result_t res,
	output logic                 res_valid
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int LB = LENGTH_BITS;

	rrp_pkg::ps_t   state_q, state_d;
	rrp_pkg::it_t   type_q, type_d;
	logic [IW-1:0]  idx_q, idx_d;
	logic [LB-1:0]  rem_q, rem_d;
	logic [LB-1:0]  alen_q, alen_d;
	logic           first_arr_q, first_arr_d;
	logic [15:0]    used_q, used_d;
	logic [15:0]    start_q, start_d;
	logic [1:0]     err_q, err_d;

	// byte classes
	logic is_cr, is_lf, is_sp, is_digit, is_prefix, is_ignored;
	assign is_cr      = (in_byte == rrp_pkg::CH_CR);
	assign is_lf      = (in_byte == rrp_pkg::CH_LF);
	assign is_sp      = (in_byte == rrp_pkg::CH_SP);
	assign is_digit   = (in_byte >= rrp_pkg::CH_ZERO) && (in_byte <= rrp_pkg::CH_NINE);
	assign is_prefix  = (in_byte == rrp_pkg::CH_STAR) || (in_byte == rrp_pkg::CH_DOLLAR);
	assign is_ignored = in_byte inside {rrp_pkg::CH_PLUS, rrp_pkg::CH_MINUS,
		rrp_pkg::CH_COLON, rrp_pkg::CH_CR, rrp_pkg::CH_LF};

	// shared arithmetic
	logic [7:0]    dig_w;
	logic [LB-1:0] rem_x10;
	logic [LB-1:0] rem_dec;
	logic          store_ok;
	logic [15:0]   used_inc;
	logic [15:0]   used_new;
	logic          idx_wrap;
	logic          last_elem;
	logic [31:0]   rem_out;
	logic [2:0]    idx_out;

	assign dig_w     = in_byte - rrp_pkg::CH_ZERO;
	assign rem_x10   = (rem_q << 3) + (rem_q << 1) + {{(LB-4){1'b0}}, dig_w[3:0]};
	assign rem_dec   = rem_q - {{(LB-1){1'b0}}, 1'b1};
	assign store_ok  = (used_q < buf_size);
	assign used_inc  = used_q + 16'd1;
	assign used_new  = store_ok ? used_inc : used_q;
	assign idx_wrap  = (idx_q == IW'(MAX_ITEMS - 1));
	assign last_elem = first_arr_q && ({{(LB-IW){1'b0}}, idx_q} == alen_q);

	generate
		if (LB >= 32) begin : g_len_trunc
			assign rem_out = rem_q[31:0];
		end else begin : g_len_ext
			assign rem_out = {{(32-LB){1'b0}}, rem_q};
		end
		if (IW >= 3) begin : g_idx_trunc
			assign idx_out = idx_q[2:0];
		end else begin : g_idx_ext
			assign idx_out = {{(3-IW){1'b0}}, idx_q};
		end
	endgenerate

	// step events
	logic        offered, has, iend, mend, adv_item, e_store;
	logic [1:0]  kind;
	logic [31:0] len;

	always_comb begin
		offered  = 1'b0;
		has      = 1'b0;
		iend     = 1'b0;
		mend     = 1'b0;
		adv_item = 1'b0;
		e_store  = 1'b0;
		kind     = rrp_pkg::KIND_ARRAY;
		len      = 32'd0;
		case (state_q)
			rrp_pkg::PS_START: begin
				if (!is_prefix && !is_ignored) begin
					offered = 1'b1;
					has     = store_ok;
					e_store = !store_ok;
				end
			end
			rrp_pkg::PS_INLINE: begin
				if (is_cr || is_lf || is_sp) begin
					iend     = 1'b1;
					kind     = rrp_pkg::KIND_INLINE;
					len      = {16'd0, used_q - start_q};
					adv_item = is_sp;
					mend     = !is_sp;
				end else begin
					offered = 1'b1;
					has     = store_ok;
					e_store = !store_ok;
				end
			end
			rrp_pkg::PS_LF: begin
				if (is_lf) begin
					if (type_q == rrp_pkg::IT_ARRAY) begin
						iend     = 1'b1;
						kind     = rrp_pkg::KIND_ARRAY;
						len      = rem_out;
						mend     = (idx_q == '0) && (rem_q == '0);
						adv_item = !mend;
					end else if (rem_q == '0) begin
						iend     = 1'b1;
						kind     = rrp_pkg::KIND_BULK;
						mend     = last_elem;
						adv_item = !last_elem;
					end
				end
			end
			rrp_pkg::PS_BUF: begin
				offered = 1'b1;
				has     = store_ok;
				e_store = !store_ok;
				if (rem_dec == '0) begin
					iend     = 1'b1;
					kind     = rrp_pkg::KIND_BULK;
					len      = {16'd0, used_new - start_q};
					mend     = last_elem;
					adv_item = !last_elem;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d     = state_q;
		type_d      = type_q;
		idx_d       = idx_q;
		rem_d       = rem_q;
		alen_d      = alen_q;
		first_arr_d = first_arr_q;
		used_d      = used_q;
		start_d     = start_q;
		case (state_q)
			rrp_pkg::PS_START: begin
				if (is_prefix) begin
					type_d  = (in_byte == rrp_pkg::CH_STAR) ? rrp_pkg::IT_ARRAY : rrp_pkg::IT_BULK;
					rem_d   = '0;
					state_d = rrp_pkg::PS_LEN;
				end else if (!is_ignored) begin
					type_d  = rrp_pkg::IT_INLINE;
					state_d = rrp_pkg::PS_INLINE;
					used_d  = used_new;
				end
			end
			rrp_pkg::PS_INLINE: begin
				if (iend) begin
					start_d = used_q;
				end else begin
					used_d = used_new;
				end
			end
			rrp_pkg::PS_LEN: begin
				if (is_cr) begin
					state_d = rrp_pkg::PS_LF;
				end else if (!is_digit) begin
					state_d = rrp_pkg::PS_START;
				end else begin
					rem_d = rem_x10;
				end
			end
			rrp_pkg::PS_LF: begin
				if (!is_lf) begin
					state_d = rrp_pkg::PS_START;
				end else if (type_q == rrp_pkg::IT_ARRAY) begin
					if (idx_q == '0) begin
						first_arr_d = 1'b1;
						alen_d      = rem_q;
					end
					state_d = rrp_pkg::PS_START;
				end else if (rem_q == '0) begin
					start_d = used_q;
					state_d = rrp_pkg::PS_START;
				end else begin
					state_d = rrp_pkg::PS_BUF;
				end
			end
			rrp_pkg::PS_BUF: begin
				used_d = used_new;
				rem_d  = rem_dec;
				if (iend) begin
					start_d = used_new;
					state_d = rrp_pkg::PS_START;
				end
			end
			default: begin
				state_d = rrp_pkg::PS_START;
			end
		endcase
		if (adv_item) begin
			idx_d = idx_wrap ? '0 : idx_q + IW'(1);
		end
		// first error of the message sticks
		if (err_q != rrp_pkg::ERR_NONE) begin
			err_d = err_q;
		end else if (e_store) begin
			err_d = rrp_pkg::ERR_OVERFLOW;
		end else if (adv_item && idx_wrap) begin
			err_d = rrp_pkg::ERR_ITEMS;
		end else begin
			err_d = rrp_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrp_pkg::PS_START;
			type_q      <= rrp_pkg::IT_UNKNOWN;
			idx_q       <= '0;
			rem_q       <= '0;
			alen_q      <= '0;
			first_arr_q <= 1'b0;
			used_q      <= '0;
			start_q     <= '0;
			err_q       <= rrp_pkg::ERR_NONE;
		end else if (step) begin
			if (mend) begin
				state_q     <= rrp_pkg::PS_START;
				type_q      <= rrp_pkg::IT_UNKNOWN;
				idx_q       <= '0;
				rem_q       <= '0;
				alen_q      <= '0;
				first_arr_q <= 1'b0;
				used_q      <= '0;
				start_q     <= '0;
				err_q       <= rrp_pkg::ERR_NONE;
			end else begin
				state_q     <= state_d;
				type_q      <= type_d;
				idx_q       <= idx_d;
				rem_q       <= rem_d;
				alen_q      <= alen_d;
				first_arr_q <= first_arr_d;
				used_q      <= used_d;
				start_q     <= start_d;
				err_q       <= err_d;
			end
		end
	end

	assign res_valid       = offered || iend;
	assign res.has_byte    = has;
	assign res.data_byte   = has ? in_byte : 8'd0;
	assign res.item_end    = iend;
	assign res.item_kind   = kind;
	assign res.item_index  = iend ? idx_out : 3'd0;
	assign res.item_length = len;
	assign res.message_end = mend;
	assign res.error       = err_d;

`ifndef SYNTHESIS
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && mend |=> idx_q == '0 && err_q == rrp_pkg::ERR_NONE && !first_arr_q)
		else $error("message state not cleared after message end");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IW'(MAX_ITEMS - 1))
		else $error("item index beyond item limit");
	a_buf_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrp_pkg::PS_BUF |-> rem_q != '0)
		else $error("bulk payload state with zero bytes left");
`endif

endmodule

### sv/resp_request_parser.sv
// top level of the streaming resp request parser
// input path: a word accepted at the input waits in the input stage until the parser steps it, and its
//   result word is registered and offered from the output register; an output stall holds both
// throughput: one byte per cycle while the output is not stalled, set by the parser step in rrp_core
// reset: arst_n clears the parser to the start state, empties both stages and loads
//   buffer_size with 1024; no clearing pass
module resp_request_parser #(
	parameter int MAX_ITEMS   = 8,
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        has_byte,
	output logic [7:0]  data_byte,
	output logic        item_end,
	output logic [1:0]  item_kind,
	output logic [2:0]  item_index,
	output logic [31:0] item_length,
	output logic        message_end,
	output logic [1:0]  error,
	// buffer size configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// input stage: one byte waiting for the parser step
	logic       valid_s1;
	logic [7:0] byte_s1;

	// output register
	logic                 out_valid_q;
	rrp_pkg::rrp_result_t res_q;

	// configuration register
	logic [15:0] buffer_size_q;

	// parser step
	rrp_pkg::rrp_result_t res;
	logic                 res_valid;
	logic                 out_free;
	logic                 step;

	// output slot is free if empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// a byte that makes no result word never waits on the output
	assign step     = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	rrp_core #(
		.MAX_ITEMS   (MAX_ITEMS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (byte_s1),
		.buf_size  (buffer_size_q),
		.res       (res),
		.res_valid (res_valid)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	// the user must write the configuration only while the parser is idle; the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= rrp_pkg::BUF_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			buffer_size_q <= cfg_data;
		end
	end

	assign out_valid   = out_valid_q;
	assign has_byte    = res_q.has_byte;
	assign data_byte   = res_q.data_byte;
	assign item_end    = res_q.item_end;
	assign item_kind   = res_q.item_kind;
	assign item_index  = res_q.item_index;
	assign item_length = res_q.item_length;
	assign message_end = res_q.message_end;
	assign error       = res_q.error;

`ifndef SYNTHESIS
	a_mend_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.message_end |-> res_q.item_end)
		else $error("message end without a finished item");
	a_byte_end_bulk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.has_byte && res_q.item_end |-> res_q.item_kind == rrp_pkg::KIND_BULK)
		else $error("content byte with item end outside a bulk string");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |-> out_free)
		else $error("result word loaded over a waiting one");
`endif

endmodule

### sim/testbench.sv
// self-checking testbench for the streaming resp request parser
`timescale 1ns / 100ps

module testbench;

	// parser geometry as built into uut
	localparam int MAX_ITEMS = 8;
	// random bytes sent after the directed part, spread over the buffer size phases
	localparam int RANDOM_BYTES = 1400;
	localparam int PHASES = 7;
	// receiver hold-off long enough to back the block up into its input
	localparam int LONG_HOLD = 150;
	// word accepted to result offered passes the input stage and the output register; a little margin on top
	localparam int SETTLE = 4;
	localparam int DRAIN_CAP = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        has_byte;
	logic [7:0]  data_byte;
	logic        item_end;
	logic [1:0]  item_kind;
	logic [2:0]  item_index;
	logic [31:0] item_length;
	logic        message_end;
	logic [1:0]  error;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	resp_request_parser #(
		.MAX_ITEMS  (MAX_ITEMS),
		.LENGTH_BITS(32)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.has_byte   (has_byte),
		.data_byte  (data_byte),
		.item_end   (item_end),
		.item_kind  (item_kind),
		.item_index (item_index),
		.item_length(item_length),
		.message_end(message_end),
		.error      (error),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// tracks the parser state byte by byte and keeps the result words it must produce
	class resp_parse_tracker;
		logic [15:0]          buf_size;
		rrp_pkg::ps_t         state;
		rrp_pkg::it_t         ityp;
		logic [2:0]           index;
		logic [31:0]          remaining;
		logic [31:0]          arr_len;
		bit                   arr_first;
		logic [15:0]          used;
		logic [15:0]          start;
		logic [1:0]           err;
		rrp_pkg::rrp_result_t expected_words[$];
		int                   mismatch_count;

		function new();
			buf_size = rrp_pkg::BUF_SIZE_RESET;
			mismatch_count = 0;
			clear_message();
		endfunction

		function void clear_message();
			state = rrp_pkg::PS_START;
			ityp = rrp_pkg::IT_UNKNOWN;
			index = '0;
			remaining = '0;
			arr_len = '0;
			arr_first = 1'b0;
			used = '0;
			start = '0;
			err = rrp_pkg::ERR_NONE;
		endfunction

		// first error of a message sticks until the message ends
		function void raise_error(logic [1:0] code);
			if (err == rrp_pkg::ERR_NONE)
				err = code;
		endfunction

		function bit store_byte();
			if (used >= buf_size) begin
				raise_error(rrp_pkg::ERR_OVERFLOW);
				return 1'b0;
			end
			used = used + 16'd1;
			return 1'b1;
		endfunction

		// index wraps past the last slot and flags too many items
		function void advance_index();
			if (index == 3'(MAX_ITEMS - 1)) begin
				raise_error(rrp_pkg::ERR_ITEMS);
				index = '0;
			end else begin
				index = index + 3'd1;
			end
		endfunction

		// a finished bulk string ends the message when it is the last array element
		function bit bulk_closes();
			if (arr_first && {29'd0, index} == arr_len)
				return 1'b1;
			advance_index();
			state = rrp_pkg::PS_START;
			return 1'b0;
		endfunction

		// one accepted input word: step the parser and note the result word, if any
		function void take_byte(logic [7:0] b);
			bit                   offered;
			bit                   kept;
			bit                   done;
			bit                   closes;
			logic [1:0]           kind;
			logic [2:0]           idx;
			logic [31:0]          len;
			rrp_pkg::rrp_result_t w;
			offered = 1'b0;
			kept = 1'b0;
			done = 1'b0;
			closes = 1'b0;
			kind = rrp_pkg::KIND_ARRAY;
			idx = '0;
			len = '0;
			case (state)
				rrp_pkg::PS_START: begin
					if (b == rrp_pkg::CH_STAR || b == rrp_pkg::CH_DOLLAR) begin
						if (b == rrp_pkg::CH_STAR)
							ityp = rrp_pkg::IT_ARRAY;
						else
							ityp = rrp_pkg::IT_BULK;
						remaining = '0;
						state = rrp_pkg::PS_LEN;
					end else if (!(b == rrp_pkg::CH_PLUS || b == rrp_pkg::CH_MINUS ||
							b == rrp_pkg::CH_COLON || b == rrp_pkg::CH_CR ||
							b == rrp_pkg::CH_LF)) begin
						ityp = rrp_pkg::IT_INLINE;
						state = rrp_pkg::PS_INLINE;
						offered = 1'b1;
						kept = store_byte();
					end
				end
				rrp_pkg::PS_INLINE: begin
					if (b == rrp_pkg::CH_CR || b == rrp_pkg::CH_LF || b == rrp_pkg::CH_SP) begin
						done = 1'b1;
						kind = rrp_pkg::KIND_INLINE;
						idx = index;
						len = {16'd0, 16'(used - start)};
						start = used;
						if (b == rrp_pkg::CH_SP) begin
							advance_index();
							ityp = rrp_pkg::IT_INLINE;
						end else begin
							closes = 1'b1;
						end
					end else begin
						offered = 1'b1;
						kept = store_byte();
					end
				end
				rrp_pkg::PS_LEN: begin
					if (b == rrp_pkg::CH_CR)
						state = rrp_pkg::PS_LF;
					else if (b < rrp_pkg::CH_ZERO || b > rrp_pkg::CH_NINE)
						state = rrp_pkg::PS_START;
					else
						remaining = remaining * 32'd10 + 32'(b - rrp_pkg::CH_ZERO);
				end
				rrp_pkg::PS_LF: begin
					if (b != rrp_pkg::CH_LF) begin
						state = rrp_pkg::PS_START;
					end else if (ityp == rrp_pkg::IT_ARRAY) begin
						done = 1'b1;
						kind = rrp_pkg::KIND_ARRAY;
						idx = index;
						len = remaining;
						if (index == 3'd0) begin
							arr_first = 1'b1;
							arr_len = remaining;
							if (remaining == 32'd0)
								closes = 1'b1;
						end
						if (!closes) begin
							advance_index();
							state = rrp_pkg::PS_START;
						end
					end else if (remaining == 32'd0) begin
						done = 1'b1;
						kind = rrp_pkg::KIND_BULK;
						idx = index;
						start = used;
						closes = bulk_closes();
					end else begin
						state = rrp_pkg::PS_BUF;
					end
				end
				rrp_pkg::PS_BUF: begin
					offered = 1'b1;
					kept = store_byte();
					remaining = remaining - 32'd1;
					if (remaining == 32'd0) begin
						done = 1'b1;
						kind = rrp_pkg::KIND_BULK;
						idx = index;
						len = {16'd0, 16'(used - start)};
						start = used;
						closes = bulk_closes();
					end
				end
				default: state = rrp_pkg::PS_START;
			endcase
			if (!offered && !done)
				return;
			w.has_byte = kept;
			w.data_byte = kept ? b : 8'h00;
			w.item_end = done;
			w.item_kind = kind;
			w.item_index = idx;
			w.item_length = len;
			w.message_end = closes;
			w.error = err;
			expected_words.push_back(w);
			if (closes)
				clear_message();
		endfunction

		function string show(rrp_pkg::rrp_result_t w);
			return $sformatf(
				"has=%0d data=%02h end=%0d kind=%0d idx=%0d len=%0d mend=%0d err=%0d",
				w.has_byte, w.data_byte, w.item_end, w.item_kind, w.item_index,
				w.item_length, w.message_end, w.error);
		endfunction

		// one accepted result word against the oldest expected one
		function void check_word(rrp_pkg::rrp_result_t got);
			rrp_pkg::rrp_result_t want;
			bit                   bad;
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: %s", show(got));
				return;
			end
			want = expected_words.pop_front();
			bad = (got.has_byte !== want.has_byte) || (got.data_byte !== want.data_byte) ||
				(got.item_end !== want.item_end) || (got.item_kind !== want.item_kind) ||
				(got.item_index !== want.item_index) ||
				(got.item_length !== want.item_length) ||
				(got.message_end !== want.message_end) || (got.error !== want.error);
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result mismatch at %0t", $time);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	resp_parse_tracker tracker = new();

	int bytes_sent = 0;
	// steady modes switch off idling on one side for a whole phase
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	// long receiver hold-offs are requested by the sender side and served by the receiver
	int holds_asked = 0;
	int holds_served = 0;

	// mostly no gap or a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// any byte that continues a word
	function automatic logic [7:0] content_byte();
		logic [7:0] b;
		b = $urandom_range(0, 255);
		while (b == rrp_pkg::CH_CR || b == rrp_pkg::CH_LF || b == rrp_pkg::CH_SP)
			b = $urandom_range(0, 255);
		return b;
	endfunction

	// a byte that opens an inline command from the start state
	function automatic logic [7:0] first_char();
		logic [7:0] b;
		b = content_byte();
		while (b == rrp_pkg::CH_STAR || b == rrp_pkg::CH_DOLLAR || b == rrp_pkg::CH_PLUS ||
				b == rrp_pkg::CH_MINUS || b == rrp_pkg::CH_COLON)
			b = content_byte();
		return b;
	endfunction

	// offer one word on the input channel, after a random gap, and wait for acceptance
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		tracker.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_crlf();
		send_byte(rrp_pkg::CH_CR);
		send_byte(rrp_pkg::CH_LF);
	endtask

	// bulk string with the given length text and content count
	task automatic send_bulk(input string digits, input int count);
		send_byte(rrp_pkg::CH_DOLLAR);
		send_text(digits);
		send_crlf();
		repeat (count) send_byte($urandom_range(0, 255));
	endtask

	// space separated words ended by CR, LF or both
	task automatic send_inline_line(input int words);
		int wlen;
		for (int w = 0; w < words; w++) begin
			if (w > 0)
				send_byte(rrp_pkg::CH_SP);
			wlen = (w == 0) ? $urandom_range(1, 5) : $urandom_range(0, 5);
			for (int c = 0; c < wlen; c++)
				send_byte((w == 0 && c == 0) ? first_char() : content_byte());
		end
		case ($urandom_range(0, 2))
			0: send_byte(rrp_pkg::CH_CR);
			1: send_byte(rrp_pkg::CH_LF);
			default: send_crlf();
		endcase
	endtask

	// array request: header then elements, mostly bulk strings
	task automatic send_array_request();
		int    count;
		int    pick;
		int    blen;
		string digits;
		count = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(8, 9);
		digits = $sformatf("%0d", count);
		// length text that wraps around 2^32 back to the small count
		if (count <= 3 && $urandom_range(0, 9) == 0)
			digits = $sformatf("429496729%0d", 6 + count);
		else if ($urandom_range(0, 9) == 0)
			digits = {"0", digits};
		send_byte(rrp_pkg::CH_STAR);
		send_text(digits);
		send_crlf();
		for (int i = 1; i <= count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// inline line inside an array ends the message at its line end
				send_inline_line($urandom_range(1, 3));
				return;
			end else if (pick < 12) begin
				// nested header takes an element slot but sets no count
				send_byte(rrp_pkg::CH_STAR);
				send_text($sformatf("%0d", $urandom_range(0, 3)));
				send_crlf();
			end else if (pick < 16) begin
				send_bulk("4294967298", 2);
			end else begin
				blen = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 6);
				send_bulk($sformatf("%0d", blen), blen);
			end
		end
		// counts past the index range never match, so close with a line end
		if (count >= 8)
			send_inline_line(1);
	endtask

	// malformed lengths and abandoned arrays
	task automatic send_broken_request();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: begin
				send_byte($urandom_range(0, 1) ? rrp_pkg::CH_STAR : rrp_pkg::CH_DOLLAR);
				send_text("1");
				b = $urandom_range(0, 255);
				if ((b >= rrp_pkg::CH_ZERO && b <= rrp_pkg::CH_NINE) || b == rrp_pkg::CH_CR)
					b = "x";
				send_byte(b);
			end
			1: begin
				send_byte($urandom_range(0, 1) ? rrp_pkg::CH_STAR : rrp_pkg::CH_DOLLAR);
				send_text("2");
				send_byte(rrp_pkg::CH_CR);
				b = $urandom_range(0, 255);
				if (b == rrp_pkg::CH_LF)
					b = "y";
				send_byte(b);
			end
			2: begin
				send_text("*3");
				send_crlf();
				send_bulk("2", 2);
				send_inline_line(1);
			end
			default: begin
				send_text("*2");
				send_crlf();
				send_text("*1");
				send_crlf();
				send_inline_line($urandom_range(1, 2));
			end
		endcase
	endtask

	// random bytes, no bulk marker so no huge content run can start; LF to resync
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 8)) begin
			b = $urandom_range(0, 255);
			if (b == rrp_pkg::CH_DOLLAR)
				b = 8'h00;
			send_byte(b);
		end
		send_byte(rrp_pkg::CH_LF);
	endtask

	task automatic send_request();
		int pick;
		if ($urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 4))
				0: send_byte(rrp_pkg::CH_PLUS);
				1: send_byte(rrp_pkg::CH_MINUS);
				2: send_byte(rrp_pkg::CH_COLON);
				3: send_byte(rrp_pkg::CH_CR);
				default: send_byte(rrp_pkg::CH_LF);
			endcase
		end
		pick = $urandom_range(0, 99);
		if (pick < 38)
			send_array_request();
		else if (pick < 70)
			send_inline_line(($urandom_range(0, 4) == 0) ? $urandom_range(6, 10) :
				$urandom_range(1, 5));
		else if (pick < 85)
			send_broken_request();
		else
			send_noise();
	endtask

	// sender stops and waits for every expected result word, with a cap
	task automatic wait_results(input int cap);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (tracker.expected_words.size() != 0 && waited < cap) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic write_buffer_size(input logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tracker.buf_size = value;
	endtask

	// result side: check each accepted word, then pick the next ready value
	initial begin : result_side
		rrp_pkg::rrp_result_t got;
		int                   stall_left;
		int                   n;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got.has_byte = has_byte;
				got.data_byte = data_byte;
				got.item_end = item_end;
				got.item_kind = item_kind;
				got.item_index = item_index;
				got.item_length = item_length;
				got.message_end = message_end;
				got.error = error;
				tracker.check_word(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (holds_served != holds_asked) begin
				// long hold-off, counted here while the sender keeps going
				holds_served = holds_asked;
				stall_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				n = rx_steady ? 0 : pick_gap();
				if (n == 0) begin
					out_ready <= 1'b1;
				end else begin
					stall_left = n - 1;
					out_ready <= 1'b0;
				end
			end
		end
	end

	// request side: reset, directed cases, then buffer size phases of random requests
	initial begin : request_side
		logic [15:0] sizes [PHASES];
		int          phase_end;
		sizes = '{16'd0, 16'd1, 16'd3, 16'd12, 16'hFFFF, 16'd40, 16'd0};
		sizes[PHASES - 1] = $urandom_range(2, 30);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored prefixes and line ends in the start state
		send_text("+-:");
		send_byte(rrp_pkg::CH_LF);
		// extreme byte values as one inline word
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(rrp_pkg::CH_CR);
		// array of one empty bulk string
		send_text("*1");
		send_crlf();
		send_text("$0");
		send_crlf();
		// empty array ends the message at once
		send_text("*0");
		send_crlf();
		// bad length digit, then a missing LF after the length
		send_text("$x");
		send_text("$1");
		send_byte(rrp_pkg::CH_CR);
		send_text("Z");
		// two inline words
		send_text("a b");
		send_byte(rrp_pkg::CH_LF);

		for (int phase = 0; phase < PHASES; phase++) begin
			// buffer size only changes with nothing in flight
			wait_results(DRAIN_CAP);
			repeat (SETTLE) @(posedge clk);
			write_buffer_size(sizes[phase]);
			tx_steady = (phase == 2 || phase == 5);
			rx_steady = (phase == 4);
			if (phase == 2 || phase == 5)
				holds_asked++;
			phase_end = bytes_sent + RANDOM_BYTES / PHASES;
			while (bytes_sent < phase_end)
				send_request();
		end

		wait_results(DRAIN_CAP);
		repeat (10) @(posedge clk);
		if (tracker.expected_words.size() != 0)
			$display("%0d expected result words never arrived",
				tracker.expected_words.size());
		if (tracker.mismatch_count == 0 && tracker.expected_words.size() == 0)
			$display("[resp_request_parser] OK");
		else
			$display("[resp_request_parser] ERROR");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#6_000_000;
		$display("[resp_request_parser] ERROR");
		$finish;
	end

endmodule
